@@ hdl/iirlp_pkg.sv @@
`timescale 1ns / 1ps

package iirlp_pkg;

  // Fixed-point format of coefficients, stored outputs and accumulator
  localparam int COEF_FRAC_BITS = 48;
  localparam int Y_FRAC         = 40;
  localparam int ACC_W          = 128;
  localparam int Y_W            = 64;
  // Rounded output before saturation: integer part of Q23.40 plus one carry bit
  localparam int RV_W           = Y_W - Y_FRAC + 1;

  // Coefficient table geometry
  localparam int TABLE_TAPS = 11;
  localparam int TIDX_W     = 4;
  localparam int CIDX_W     = 5;

  // Multiply-accumulate pipeline depth after the operand registers
  localparam int PIPE_DEPTH = 3;

  localparam logic [63:0] DEC10 = 64'd10000000000;

  // Convert sign, integer part and 20 decimal fraction digits to Q.COEF_FRAC_BITS,
  // rounded half up (evaluated at elaboration only)
  function automatic logic [63:0] coef_q(input logic neg, input logic [63:0] ip,
                                         input logic [63:0] dhi, input logic [63:0] dlo);
    logic [63:0] h;
    logic [63:0] l;
    logic [63:0] frac;
    logic [63:0] v;
    logic        carry;
    logic        bit_v;
    h    = dhi;
    l    = dlo;
    frac = 64'd0;
    for (int i = 0; i <= COEF_FRAC_BITS; i++) begin
      l     = l << 1;
      carry = (l >= DEC10);
      if (carry) l = l - DEC10;
      h     = (h << 1) + 64'(carry);
      bit_v = (h >= DEC10);
      if (bit_v) h = h - DEC10;
      if (i < COEF_FRAC_BITS) frac = (frac << 1) | 64'(bit_v);
      else frac = frac + 64'(bit_v);
    end
    v = (ip << COEF_FRAC_BITS) + frac;
    return neg ? (64'd0 - v) : v;
  endfunction

  // Feed-forward coefficients a[n]
  localparam logic [63:0] COEF_A [TABLE_TAPS] = '{
    coef_q(1'b0, 64'd0, 64'd13606,   64'd6890274772),
    coef_q(1'b0, 64'd0, 64'd136066,  64'd8902747718),
    coef_q(1'b0, 64'd0, 64'd612301,  64'd62364732),
    coef_q(1'b0, 64'd0, 64'd1632802, 64'd6832972619),
    coef_q(1'b0, 64'd0, 64'd2857404, 64'd6957702086),
    coef_q(1'b0, 64'd0, 64'd3428885, 64'd6349242504),
    coef_q(1'b0, 64'd0, 64'd2857404, 64'd6957702086),
    coef_q(1'b0, 64'd0, 64'd1632802, 64'd6832972619),
    coef_q(1'b0, 64'd0, 64'd612301,  64'd62364732),
    coef_q(1'b0, 64'd0, 64'd136066,  64'd8902747718),
    coef_q(1'b0, 64'd0, 64'd13606,   64'd6890274772)
  };

  // Feedback coefficients, stored negated (-b[n]) so every tap accumulates
  localparam logic [63:0] COEF_BN [TABLE_TAPS] = '{
    coef_q(1'b1, 64'd1,  64'd0,          64'd0),
    coef_q(1'b0, 64'd5,  64'd6788882885, 64'd6097480000),
    coef_q(1'b1, 64'd14, 64'd9535090668, 64'd2947000000),
    coef_q(1'b0, 64'd23, 64'd9589421056, 64'd3200500000),
    coef_q(1'b1, 64'd25, 64'd7945973585, 64'd8526100000),
    coef_q(1'b0, 64'd19, 64'd4532333022, 64'd7612100000),
    coef_q(1'b1, 64'd10, 64'd3872986317, 64'd6669500000),
    coef_q(1'b0, 64'd3,  64'd8711735581, 64'd7402630000),
    coef_q(1'b1, 64'd0,  64'd9623041507, 64'd5654718000),
    coef_q(1'b0, 64'd0,  64'd1438973787, 64'd9329331000),
    coef_q(1'b1, 64'd0,  64'd98183923,   64'd923440410)
  };

  // Table lookups; taps beyond the table have zero coefficients
  function automatic logic [63:0] coef_ff(input logic [CIDX_W-1:0] n);
    return (n < CIDX_W'(TABLE_TAPS)) ? COEF_A[n[TIDX_W-1:0]] : 64'd0;
  endfunction

  function automatic logic [63:0] coef_fb(input logic [CIDX_W-1:0] n);
    return (n < CIDX_W'(TABLE_TAPS)) ? COEF_BN[n[TIDX_W-1:0]] : 64'd0;
  endfunction

  // Controller commands to the datapath
  typedef struct packed {
    logic load;    // capture the request sample, preset the accumulator
    logic issue;   // fetch operands of the current tap
    logic finish;  // round, update histories, load the result register
  } iirlp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } iirlp_state_e;

endpackage

@@ hdl/iirlp_in_if.sv @@
`timescale 1ns / 1ps

interface iirlp_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/iirlp_out_if.sv @@
`timescale 1ns / 1ps

interface iirlp_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          clipped;

  modport source (output valid, output filtered, output clipped, input ready);
  modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

@@ hdl/iirlp_ctrl.sv @@
`timescale 1ns / 1ps

module iirlp_ctrl #(
  parameter int ORDER = 10,
  parameter int TAP_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output iirlp_pkg::iirlp_cmd_t cmd_o,
  output logic [TAP_W-1:0]    tap_o
);
  import iirlp_pkg::*;

  localparam int DRAIN_W = $clog2(PIPE_DEPTH);
  localparam logic [TAP_W-1:0]   LAST_TAP  = TAP_W'(2 * ORDER);
  localparam logic [DRAIN_W-1:0] LAST_DRAIN = DRAIN_W'(PIPE_DEPTH - 1);

  iirlp_state_e       state_q, state_d;
  logic [TAP_W-1:0]   tap_q, tap_d;
  logic [DRAIN_W-1:0] drain_q, drain_d;
  logic               out_valid_q, out_valid_d;

  // State, tap counter and result-pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence one request: accept, issue every tap, drain, finish
  always_comb begin
    state_d     = state_q;
    tap_d       = tap_q;
    drain_d     = drain_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          tap_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (tap_q == LAST_TAP) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_q == LAST_DRAIN) state_d = ST_FINISH;
        else drain_d = drain_q + DRAIN_W'(1);
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign tap_o       = tap_q;

endmodule

@@ hdl/iirlp_datapath.sv @@
`timescale 1ns / 1ps

module iirlp_datapath #(
  parameter int ORDER       = 10,
  parameter int SAMPLE_BITS = 16,
  parameter int TAP_W       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iirlp_pkg::iirlp_cmd_t         cmd_i,
  input  logic [TAP_W-1:0]              tap_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  output logic                          clipped_o
);
  import iirlp_pkg::*;

  localparam int HIDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RV_W-1:0] SMAX = RV_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RV_W-1:0] SMIN = RV_W'(-(2 ** (SAMPLE_BITS - 1)));
  localparam logic [Y_W-1:0] Y_MAX = {1'b0, {(Y_W - 1){1'b1}}};
  localparam logic [Y_W-1:0] Y_MIN = {1'b1, {(Y_W - 1){1'b0}}};

  // Sample scaled to the feedback scale (Q.Y_FRAC in 64 bits)
  function automatic logic [Y_W-1:0] align_x(input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [Y_W-1:0] e;
    e = Y_W'(x);
    return e <<< Y_FRAC;
  endfunction

  // Filter state
  logic signed [SAMPLE_BITS-1:0] x_hist_q [ORDER];
  logic [Y_W-1:0]                y_hist_q [ORDER];
  logic signed [SAMPLE_BITS-1:0] x0_q;

  // Pipeline registers
  logic [63:0]        cf_q, cf_d;
  logic [Y_W-1:0]     op_q, op_d;
  logic signed [65:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [65:0] p00_d, p01_d, p10_d, p11_d;
  logic [ACC_W-1:0]   prod_q, prod_d;
  logic [ACC_W-1:0]   acc_q;
  logic               v0_q, v1_q, v2_q;

  logic signed [SAMPLE_BITS-1:0] filtered_q;
  logic                          clipped_q;

  // Tap decode
  logic [TAP_W-1:0]  tap_m1, tap_fb, tap_fbm1;
  logic [HIDX_W-1:0] hidx_x, hidx_y;

  assign tap_m1   = tap_i - TAP_W'(1);
  assign tap_fb   = tap_i - TAP_W'(ORDER);
  assign tap_fbm1 = tap_i - TAP_W'(ORDER + 1);
  assign hidx_x   = tap_m1[HIDX_W-1:0];
  assign hidx_y   = tap_fbm1[HIDX_W-1:0];

  // Select coefficient and operand of the current tap
  always_comb begin
    if (tap_i == '0) begin
      cf_d = coef_ff('0);
      op_d = align_x(x0_q);
    end else if (tap_i <= TAP_W'(ORDER)) begin
      cf_d = coef_ff(CIDX_W'(tap_i));
      op_d = align_x(x_hist_q[hidx_x]);
    end else begin
      cf_d = coef_fb(CIDX_W'(tap_fb));
      op_d = y_hist_q[hidx_y];
    end
  end

  // Four 33x33 partial products of the 64x64 signed product
  logic signed [32:0] c_lo, c_hi, o_lo, o_hi;
  assign c_lo = {1'b0, cf_q[31:0]};
  assign c_hi = {cf_q[63], cf_q[63:32]};
  assign o_lo = {1'b0, op_q[31:0]};
  assign o_hi = {op_q[63], op_q[63:32]};

  always_comb begin
    p00_d = c_lo * o_lo;
    p01_d = c_lo * o_hi;
    p10_d = c_hi * o_lo;
    p11_d = c_hi * o_hi;
  end

  // Combine partial products into the full 128-bit product
  logic signed [ACC_W-1:0] m01, m10;
  always_comb begin
    m01    = ACC_W'(p01_q);
    m10    = ACC_W'(p10_q);
    prod_d = {p11_q[63:0], p00_q[63:0]} + (m01 <<< 32) + (m10 <<< 32);
  end

  // Round the sum to Q23.40, saturate to 64 bits, then to the sample range
  logic                   acc_ovf;
  logic [Y_W-1:0]         y_new;
  logic signed [RV_W-1:0] rv;
  logic signed [SAMPLE_BITS-1:0] filt_d;
  logic                   clip_d;

  always_comb begin
    acc_ovf = !((acc_q[ACC_W-1:COEF_FRAC_BITS+Y_W-1] == '0) ||
                (acc_q[ACC_W-1:COEF_FRAC_BITS+Y_W-1] == '1));
    if (acc_ovf) y_new = acc_q[ACC_W-1] ? Y_MIN : Y_MAX;
    else y_new = acc_q[COEF_FRAC_BITS+Y_W-1:COEF_FRAC_BITS];
    rv = RV_W'($signed(y_new[Y_W-1:Y_FRAC])) + RV_W'({1'b0, y_new[Y_FRAC-1]});
    if (rv > SMAX) begin
      filt_d = SMAX[SAMPLE_BITS-1:0];
      clip_d = 1'b1;
    end else if (rv < SMIN) begin
      filt_d = SMIN[SAMPLE_BITS-1:0];
      clip_d = 1'b1;
    end else begin
      filt_d = rv[SAMPLE_BITS-1:0];
      clip_d = 1'b0;
    end
  end

  // Advance the product pipeline
  always_ff @(posedge clk_i) begin
    cf_q   <= cf_d;
    op_q   <= op_d;
    p00_q  <= p00_d;
    p01_q  <= p01_d;
    p10_q  <= p10_d;
    p11_q  <= p11_d;
    prod_q <= prod_d;
    if (cmd_i.load) x0_q <= sample_i;
  end

  // Track which pipeline slots carry a tap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // Preset with the rounding constant, then accumulate every product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) acc_q <= RND;
    else if (v2_q) acc_q <= acc_q + prod_q;
  end

  // Shift histories on finish; they start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER; i++) begin
        x_hist_q[i] <= '0;
        y_hist_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      for (int i = 1; i < ORDER; i++) begin
        x_hist_q[i] <= x_hist_q[i-1];
        y_hist_q[i] <= y_hist_q[i-1];
      end
      x_hist_q[0] <= x0_q;
      y_hist_q[0] <= y_new;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      filtered_q <= filt_d;
      clipped_q  <= clip_d;
    end
  end

  assign filtered_o = filtered_q;
  assign clipped_o  = clipped_q;

endmodule

@@ hdl/iir_lowpass_order10_unit.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// in_i      in   valid / ready      sample   (SAMPLE_BITS, signed)
// out_o     out  valid / ready      filtered (SAMPLE_BITS, signed), clipped (1)
//
// After a request is accepted, the result is valid once the controller has issued
// 2*ORDER+1 taps on the single shared multiply-accumulate pipeline, drained it and
// finished. A new request is taken only in idle, after the finish of the last one.
// Reset clears both histories to zero and leaves no result pending.
// A result held by a stalled sink blocks only the final step; the next request is
// accepted and computed meanwhile.

module iir_lowpass_order10_unit #(
  parameter int ORDER       = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iirlp_in_if.sink    in_i,
  iirlp_out_if.source out_o
);
  import iirlp_pkg::*;

  localparam int TAP_W = $clog2(2 * ORDER + 1);

  iirlp_cmd_t       cmd;
  logic [TAP_W-1:0] tap;

  iirlp_ctrl #(
    .ORDER (ORDER),
    .TAP_W (TAP_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .tap_o       (tap)
  );

  iirlp_datapath #(
    .ORDER       (ORDER),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_W       (TAP_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .tap_i      (tap),
    .sample_i   (in_i.sample),
    .filtered_o (out_o.filtered),
    .clipped_o  (out_o.clipped)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import iirlp_pkg::*;

  localparam int FILTER_ORDER = 10;
  localparam int SAMPLE_W     = 16;
  localparam int Q_FRAC       = 40;
  localparam int C_FRAC       = 48;
  localparam int LATENCY      = 2 * FILTER_ORDER + 6;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_HOLD    = 300;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [127:0] Y_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] Y_MIN = -Y_MAX - 128'sd1;
  localparam logic [127:0] TEN_POW10 = 128'd10_000_000_000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } filt_result_t;

  // Shapes of random stimulus segments
  typedef enum logic [1:0] {
    SEG_RAIL,    // full-scale level, alternating rails, long enough to settle
    SEG_LEVEL,   // random constant level
    SEG_NOISE,   // every bit random
    SEG_JITTER   // random level with the low bits wobbling
  } seg_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iirlp_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  iirlp_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_if ();

  iir_lowpass_order10_unit #(
    .ORDER      (FILTER_ORDER),
    .SAMPLE_BITS(SAMPLE_W)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk = ~clk;

  // Filter coefficients in Q.48 and the filter's own history
  logic signed [63:0]         ff_coef [FILTER_ORDER+1];
  logic signed [63:0]         fb_coef [FILTER_ORDER+1];
  logic signed [SAMPLE_W-1:0] x_hist  [FILTER_ORDER] = '{default: '0};
  logic signed [63:0]         y_hist  [FILTER_ORDER] = '{default: '0};

  filt_result_t pending_outputs[$];

  int src_idle_pct    = 0;
  int sink_idle_pct   = 0;
  int sink_hold       = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int clip_count      = 0;
  int mismatch_count  = 0;
  bit last_rail_high  = 1'b0;

  // Convert sign, integer part and 20 fraction digits (two halves) to Q.48, half up
  function automatic logic signed [63:0] q48(input bit neg, input longint unsigned whole,
                                             input longint unsigned hi10,
                                             input longint unsigned lo10);
    logic [127:0] digits;
    logic [127:0] q;
    digits = 128'(hi10) * TEN_POW10 + 128'(lo10);
    q = ((digits << (C_FRAC + 1)) / (TEN_POW10 * TEN_POW10) + 128'd1) >> 1;
    q = q + (128'(whole) << C_FRAC);
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  initial begin
    ff_coef[0]  = q48(1'b0, 0, 64'd13606,   64'd6890274772);
    ff_coef[1]  = q48(1'b0, 0, 64'd136066,  64'd8902747718);
    ff_coef[2]  = q48(1'b0, 0, 64'd612301,  64'd62364732);
    ff_coef[3]  = q48(1'b0, 0, 64'd1632802, 64'd6832972619);
    ff_coef[4]  = q48(1'b0, 0, 64'd2857404, 64'd6957702086);
    ff_coef[5]  = q48(1'b0, 0, 64'd3428885, 64'd6349242504);
    ff_coef[6]  = ff_coef[4];
    ff_coef[7]  = ff_coef[3];
    ff_coef[8]  = ff_coef[2];
    ff_coef[9]  = ff_coef[1];
    ff_coef[10] = ff_coef[0];
    fb_coef[0]  = q48(1'b0, 1,  64'd0,          64'd0);
    fb_coef[1]  = q48(1'b1, 5,  64'd6788882885, 64'd6097480000);
    fb_coef[2]  = q48(1'b0, 14, 64'd9535090668, 64'd2947000000);
    fb_coef[3]  = q48(1'b1, 23, 64'd9589421056, 64'd3200500000);
    fb_coef[4]  = q48(1'b0, 25, 64'd7945973585, 64'd8526100000);
    fb_coef[5]  = q48(1'b1, 19, 64'd4532333022, 64'd7612100000);
    fb_coef[6]  = q48(1'b0, 10, 64'd3872986317, 64'd6669500000);
    fb_coef[7]  = q48(1'b1, 3,  64'd8711735581, 64'd7402630000);
    fb_coef[8]  = q48(1'b0, 0,  64'd9623041507, 64'd5654718000);
    fb_coef[9]  = q48(1'b1, 0,  64'd1438973787, 64'd9329331000);
    fb_coef[10] = q48(1'b0, 0,  64'd98183923,   64'd923440410);
  end

  // Run one sample through the filter and return the rounded, saturated output
  function automatic filt_result_t filter_step(input logic signed [SAMPLE_W-1:0] x);
    logic signed [127:0] fwd;
    logic signed [127:0] back;
    logic signed [127:0] acc;
    logic signed [63:0]  y_new;
    logic signed [63:0]  whole;
    filt_result_t        res;
    fwd  = ff_coef[0] * x;
    back = '0;
    for (int n = 1; n <= FILTER_ORDER; n++) begin
      fwd  = fwd + ff_coef[n] * x_hist[n-1];
      back = back - fb_coef[n] * y_hist[n-1];
    end
    // Align feed-forward to Q.88, round half up to Q23.40 and saturate to 64 bits
    acc = (fwd <<< Q_FRAC) + back + (128'sd1 <<< (C_FRAC - 1));
    acc = acc >>> C_FRAC;
    if (acc > Y_MAX) y_new = Y_MAX[63:0];
    else if (acc < Y_MIN) y_new = Y_MIN[63:0];
    else y_new = acc[63:0];
    for (int n = FILTER_ORDER - 1; n > 0; n--) begin
      x_hist[n] = x_hist[n-1];
      y_hist[n] = y_hist[n-1];
    end
    x_hist[0] = x;
    y_hist[0] = y_new;
    // Round to an integer and clip to the sample range
    whole = y_new >>> Q_FRAC;
    if (y_new[Q_FRAC-1]) whole = whole + 64'sd1;
    res.clipped = 1'b1;
    if (whole > 64'(S_MAX)) res.filtered = S_MAX;
    else if (whole < 64'(S_MIN)) res.filtered = S_MIN;
    else begin
      res.filtered = whole[SAMPLE_W-1:0];
      res.clipped  = 1'b0;
    end
    return res;
  endfunction

  // Offer one request, idling at random first; predict on acceptance
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= SAMPLE_W'($urandom);
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= value;
    do @(posedge clk); while (!in_if.ready);
    pending_outputs.push_back(filter_step(value));
    samples_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Hold the input until every predicted result has come out
  task automatic wait_drained();
    stop_sending();
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Receiver: random stalls, plus long hold-offs counted down here
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_if.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    filt_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (out_if.clipped) clip_count++;
      if (pending_outputs.size() == 0) begin
        note_mismatch($sformatf("result %0d/%0b with none expected",
                                out_if.filtered, out_if.clipped));
      end else begin
        want = pending_outputs.pop_front();
        results_checked++;
        if (out_if.filtered !== want.filtered)
          note_mismatch($sformatf("result %0d: filtered expected %0d, got %0d",
                                  results_checked, want.filtered, out_if.filtered));
        if (out_if.clipped !== want.clipped)
          note_mismatch($sformatf("result %0d: clipped expected %0b, got %0b",
                                  results_checked, want.clipped, out_if.clipped));
      end
    end
  end

  // Extremes, single bits, alternating patterns and a full-scale swing
  task automatic test_directed();
    logic signed [SAMPLE_W-1:0] vals[$];
    vals = '{16'sd0, 16'sd1, -16'sd1, S_MAX, S_MIN, S_MAX, S_MIN, 16'sh5555,
             16'shAAAA, 16'sh0001, 16'sh8001, 16'sh7FFE, 16'sh00FF, 16'shFF00,
             S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, 16'sd0, 16'sd0};
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    foreach (vals[i]) send_sample(vals[i]);
    wait_drained();
  endtask

  // Stall the output long enough that the input stalls too
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold     = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_sample(SAMPLE_W'($urandom));
    wait_drained();
  endtask

  // Segments of rails, levels and noise; rail segments drive full-scale steps
  task automatic test_random(input int items, input int src_pct, input int snk_pct);
    seg_kind_e                  kind;
    int                         left;
    int                         seg_len;
    logic signed [SAMPLE_W-1:0] level;
    logic signed [SAMPLE_W-1:0] v;
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    left = items;
    while (left > 0) begin
      kind = seg_kind_e'($urandom_range(3));
      seg_len = (kind == SEG_RAIL) ? $urandom_range(160, 60) : $urandom_range(40, 5);
      if (seg_len > left) seg_len = left;
      if (kind == SEG_RAIL) begin
        last_rail_high = !last_rail_high;
        level = last_rail_high ? S_MAX : S_MIN;
      end else begin
        level = SAMPLE_W'($urandom);
      end
      for (int i = 0; i < seg_len; i++) begin
        case (kind)
          SEG_NOISE:  v = SAMPLE_W'($urandom);
          SEG_JITTER: v = level ^ SAMPLE_W'($urandom_range(63));
          default:    v = level;
        endcase
        send_sample(v);
      end
      left -= seg_len;
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random(380, 38, 56);
    test_random(380, 56, 38);
    test_random(380, 0, 0);

    // Let any stray result show up
    repeat (2 * LATENCY) @(posedge clk);
    if (pending_outputs.size() != 0) note_mismatch("results still expected at the end");

    $display("Ran %0d samples: directed extremes, a long output stall, and rail steps,",
             samples_sent);
    $display("levels and noise under mixed stalls; %0d results checked, %0d clipped.",
             results_checked, clip_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout after %0d samples and %0d results", samples_sent, results_checked);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
